@@ rtl/epx_pkg.sv @@
// ----------------------------------------------------------------------------
// epx_pkg
// shared payload types, register codes and queue sizing for the scale2x core
// ----------------------------------------------------------------------------
package epx_pkg;

  localparam int PIX_W     = 8;
  localparam int COORD_W   = 10;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd320;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd240;

  // input item kinds
  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_LVL_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic             mode;
    logic [PIX_W-1:0] pixel;
  } epx_in_t;

  typedef struct packed {
    logic [PIX_W-1:0]   top_left;
    logic [PIX_W-1:0]   top_right;
    logic [PIX_W-1:0]   bottom_left;
    logic [PIX_W-1:0]   bottom_right;
    logic [COORD_W-1:0] src_col;
    logic [COORD_W-1:0] src_row;
    logic               frame_end;
  } epx_out_t;

  // one classified block: centre and its four neighbors, edges already resolved
  typedef struct packed {
    logic [PIX_W-1:0]   p;
    logic [PIX_W-1:0]   a;
    logic [PIX_W-1:0]   b;
    logic [PIX_W-1:0]   c;
    logic [PIX_W-1:0]   d;
    logic [COORD_W-1:0] src_col;
    logic [COORD_W-1:0] src_row;
    logic               frame_end;
  } epx_blk_t;

  typedef struct packed {
    logic room;
    logic empty;
  } epx_qstat_t;

endpackage

@@ rtl/epx_front.sv @@
// ----------------------------------------------------------------------------
// epx_front
// accepts beats, tracks raster position, owns the row store and fetches the
// neighborhood of each block that is due
// ----------------------------------------------------------------------------
module epx_front
  import epx_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  epx_in_t              in_data,
  output logic                 push,
  output epx_blk_t             push_data
);

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int RW    = $clog2(MAX_HEIGHT + 1);
  localparam int AW    = XW + 1;
  localparam int DEPTH = 2 ** AW;

  logic [CFG_W-1:0] image_width_r;
  logic [CFG_W-1:0] image_height_r;
  logic [WW-1:0]    w_eff;
  logic [RW-1:0]    h_eff;

  logic [XW-1:0] in_col_r, in_col_nxt;
  logic [XW-1:0] drain_col_r, drain_col_nxt;
  logic [RW-1:0] in_row_r, in_row_nxt;
  logic          rsel_r, rsel_nxt;

  logic          fire, is_flush, frame_full, pix_take, flush_take, emit, at_end;
  logic [XW-1:0] col;
  logic [WW-1:0] col_inc;
  logic [AW-1:0] addr_p, addr_a, addr_b, addr_c, addr_w;

  logic [PIX_W-1:0] mem0 [DEPTH];
  logic [PIX_W-1:0] mem1 [DEPTH];
  logic [PIX_W-1:0] p_rd_r, a_rd_r, b_rd_r, c_rd_r;

  logic             s1_valid_r;
  logic [XW-1:0]    s1_col_r;
  logic [RW-1:0]    s1_row_r;
  logic             s1_above_r, s1_has_b_r, s1_has_c_r, s1_d_is_p_r, s1_last_r;
  logic [PIX_W-1:0] s1_d_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= WIDTH_RESET;
      image_height_r <= HEIGHT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width_r  <= cfg_data;
        CFG_IMAGE_HEIGHT: image_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp to the legal range
  always_comb begin
    if (image_width_r == '0)
      w_eff = WW'(1);
    else if (32'(image_width_r) > MAX_WIDTH)
      w_eff = WW'(MAX_WIDTH);
    else
      w_eff = WW'(image_width_r);

    if (image_height_r == '0)
      h_eff = RW'(1);
    else if (32'(image_height_r) > MAX_HEIGHT)
      h_eff = RW'(MAX_HEIGHT);
    else
      h_eff = RW'(image_height_r);
  end

  // classify the beat
  always_comb begin
    fire       = in_valid && in_ready;
    is_flush   = (in_data.mode == MODE_FLUSH);
    col        = is_flush ? drain_col_r : in_col_r;
    col_inc    = WW'(col) + WW'(1);
    at_end     = (col_inc >= w_eff);
    frame_full = (in_row_r >= h_eff);
    pix_take   = fire && !is_flush && !frame_full;
    flush_take = fire && is_flush && frame_full;
    emit       = (pix_take && (in_row_r != '0)) || flush_take;

    addr_p = {rsel_r, col};
    addr_a = {~rsel_r, col};
    addr_b = {rsel_r, XW'(col_inc)};
    addr_c = {rsel_r, col - XW'(1)};
    addr_w = {~rsel_r, in_col_r};
  end

  // raster position
  always_comb begin
    in_col_nxt    = in_col_r;
    in_row_nxt    = in_row_r;
    drain_col_nxt = drain_col_r;
    rsel_nxt      = rsel_r;
    if (pix_take) begin
      if (at_end) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + RW'(1);
        rsel_nxt   = ~rsel_r;
      end else begin
        in_col_nxt = XW'(col_inc);
      end
    end else if (flush_take) begin
      if (at_end) begin
        in_col_nxt    = '0;
        in_row_nxt    = '0;
        drain_col_nxt = '0;
        rsel_nxt      = 1'b0;
      end else begin
        drain_col_nxt = XW'(col_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r    <= '0;
      in_row_r    <= '0;
      drain_col_r <= '0;
      rsel_r      <= 1'b0;
      s1_valid_r  <= 1'b0;
    end else begin
      in_col_r    <= in_col_nxt;
      in_row_r    <= in_row_nxt;
      drain_col_r <= drain_col_nxt;
      rsel_r      <= rsel_nxt;
      s1_valid_r  <= emit;
    end
  end

  // row store, two copies with two read ports each
  always_ff @(posedge clk) begin
    if (pix_take) begin
      mem0[addr_w] <= in_data.pixel;
      mem1[addr_w] <= in_data.pixel;
    end
    if (fire) begin
      p_rd_r <= mem0[addr_p];
      a_rd_r <= mem0[addr_a];
      b_rd_r <= mem1[addr_b];
      c_rd_r <= mem1[addr_c];
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      s1_col_r    <= col;
      s1_row_r    <= in_row_r - RW'(1);
      s1_above_r  <= (in_row_r > RW'(1));
      s1_has_b_r  <= !at_end;
      s1_has_c_r  <= (col != '0);
      s1_d_r      <= in_data.pixel;
      s1_d_is_p_r <= is_flush;
      s1_last_r   <= is_flush && at_end;
    end
  end

  // missing neighbors fall back to the centre
  always_comb begin
    push              = s1_valid_r;
    push_data.p       = p_rd_r;
    push_data.a       = s1_above_r  ? a_rd_r : p_rd_r;
    push_data.b       = s1_has_b_r  ? b_rd_r : p_rd_r;
    push_data.c       = s1_has_c_r  ? c_rd_r : p_rd_r;
    push_data.d       = s1_d_is_p_r ? p_rd_r : s1_d_r;
    push_data.src_col = COORD_W'(s1_col_r);
    push_data.src_row = COORD_W'(s1_row_r);
    push_data.frame_end = s1_last_r;
  end

endmodule

@@ rtl/epx_queue.sv @@
// ----------------------------------------------------------------------------
// epx_queue
// short fifo of classified blocks between front and back
// ----------------------------------------------------------------------------
module epx_queue
  import epx_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  epx_blk_t   push_data,
  input  logic       pop,
  output epx_blk_t   head,
  output epx_qstat_t stat
);

  epx_blk_t               slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QUEUE_LVL_W-1:0] level_r, level_nxt;

  always_comb begin
    head       = slots[rd_ptr_r];
    stat.empty = (level_r == '0);
    // room for a beat accepted now, counting the block already in flight
    stat.room  = (32'(level_r) + 32'(push)) < QUEUE_DEPTH;
    level_nxt  = level_r;
    if (push && !pop)
      level_nxt = level_r + QUEUE_LVL_W'(1);
    else if (pop && !push)
      level_nxt = level_r - QUEUE_LVL_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (push)
        wr_ptr_r <= wr_ptr_r + QUEUE_PTR_W'(1);
      if (pop)
        rd_ptr_r <= rd_ptr_r + QUEUE_PTR_W'(1);
      level_r <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push)
      slots[wr_ptr_r] <= push_data;
  end

endmodule

@@ rtl/epx_back.sv @@
// ----------------------------------------------------------------------------
// epx_back
// applies the epx rules to the queue head and holds the result beat
// ----------------------------------------------------------------------------
module epx_back
  import epx_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  epx_blk_t   head,
  input  epx_qstat_t stat,
  output logic       pop,
  input  logic       out_ready,
  output logic       out_valid,
  output epx_out_t   out_data
);

  logic     out_valid_r;
  epx_out_t out_data_r, out_data_nxt;

  always_comb begin
    pop = !stat.empty && (!out_valid_r || out_ready);

    out_data_nxt.top_left     = head.p;
    out_data_nxt.top_right    = head.p;
    out_data_nxt.bottom_left  = head.p;
    out_data_nxt.bottom_right = head.p;
    if (head.c == head.a && head.c != head.d && head.a != head.b)
      out_data_nxt.top_left = head.a;
    if (head.a == head.b && head.a != head.c && head.b != head.d)
      out_data_nxt.top_right = head.b;
    if (head.d == head.c && head.d != head.b && head.c != head.a)
      out_data_nxt.bottom_left = head.c;
    if (head.b == head.d && head.b != head.a && head.d != head.c)
      out_data_nxt.bottom_right = head.d;
    out_data_nxt.src_col   = head.src_col;
    out_data_nxt.src_row   = head.src_row;
    out_data_nxt.frame_end = head.frame_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop)
      out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ rtl/epx_scale2x_upscaler_core.sv @@
// ----------------------------------------------------------------------------
// epx_scale2x_upscaler_core
// a block passes the fetch registers, the queue and the output register
// throughput: one beat per cycle when the queue has room (dual-copy row store)
// reset: synchronous active low, clears position counters, queue and output
//   valid, loads width 320 and height 240; the row store is not cleared
// streaming epx / scale2x 2x pixel-art upscaler over 8-bit palette pixels
// ----------------------------------------------------------------------------
module epx_scale2x_upscaler_core
  import epx_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  // source pixel / flush beats
  input  logic                 in_valid,
  output logic                 in_ready,
  input  epx_in_t              in_data,
  // 2x2 output blocks
  output logic                 out_valid,
  input  logic                 out_ready,
  output epx_out_t             out_data
);

  // front -> queue
  logic       push;
  epx_blk_t   push_data;
  // queue -> back
  epx_blk_t   head;
  epx_qstat_t qstat;
  logic       pop;

  // register writes never stall
  assign cfg_ready = 1'b1;

  // take a beat only if the queue can absorb the block it may produce,
  // so the fetch stage never has to hold
  assign in_ready = qstat.room;

  // front: raster counters, flush drain, row store fetch
  epx_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .push      (push),
    .push_data (push_data)
  );

  // decoupling queue
  epx_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .stat      (qstat)
  );

  // back: epx rules and output register
  epx_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .stat      (qstat),
    .pop       (pop),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
